// ----- hw/rtl/swdq_pkg.sv -----
// shared types and constants for the sorted wakeup delay queue
// no dependencies
`default_nettype none

package swdq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TASK_ID_BITS_DEF = 8;
    localparam int MAX_RESULTS      = 16;
    localparam int CNT_W            = $clog2(MAX_RESULTS);

    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int TID_W   = 8;
    localparam int REQ_W   = 31;
    localparam int TICKS_W = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_TIME  = 2'd1,
        OP_DELAY = 2'd2,
        OP_UNTIL = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WAKE = 2'd0,
        KIND_TIME = 2'd1,
        KIND_NOW  = 2'd2,
        KIND_FULL = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_BURST
    } state_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_wakeup_delay_queue.sv -----
// a time query or delay answer is registered from the DECIDE state once the output is free
// a tick releases due tasks in BURST, one word per cycle unless stalled, at most 16 per tick
// one request at a time: the input is ready only in the IDLE state
// queue slots shift left on release and right of the insert point on insertion
// reset: asynchronous active low, clears the time counter, slot valid bits and control
// top level: sorted wakeup delay queue built from a chain of swdq_cell slots, uses swdq_pkg
`default_nettype none

module sorted_wakeup_delay_queue #(
    parameter int QUEUE_DEPTH  = swdq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = swdq_pkg::TASK_ID_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [swdq_pkg::S_DATA_W-1:0]     s_tdata,  // task_id, request_ticks, pad
    input  wire logic [swdq_pkg::OP_W-1:0]         s_tuser,  // operation
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [swdq_pkg::M_DATA_W-1:0]          m_tdata,  // reply_task, reply_ticks
    output logic [swdq_pkg::KIND_W-1:0]            m_tuser,  // kind
    output logic                                   m_tlast
);
    import swdq_pkg::*;

    localparam int TW = (TASK_ID_BITS < TID_W) ? TASK_ID_BITS : TID_W;

    state_t              state_reg, state_next;
    logic [TICKS_W-1:0]  time_reg, time_next;
    op_t                 op_reg, op_next;
    logic [TW-1:0]       tid_reg, tid_next;
    logic [TICKS_W-1:0]  dl_reg, dl_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [TID_W-1:0]    out_tid_reg, out_tid_next;
    logic [TICKS_W-1:0]  out_ticks_reg, out_ticks_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                front_due;
    logic                second_due;
    logic                burst_last;
    logic                later;
    cell_cmd_t           cmd;
    logic [REQ_W-1:0]    req;

    logic                cell_valid [QUEUE_DEPTH];
    logic                cell_gt    [QUEUE_DEPTH];
    logic [TICKS_W-1:0]  cell_dl    [QUEUE_DEPTH];
    logic [TW-1:0]       cell_tid   [QUEUE_DEPTH];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign req      = s_tdata[TID_W +: REQ_W];

    assign front_due  = cell_valid[0] && (cell_dl[0] <= time_reg);
    assign second_due = cell_valid[1] && (cell_dl[1] <= time_reg);
    assign burst_last = (cnt_reg == CNT_W'(MAX_RESULTS - 1)) || !second_due;
    assign later      = dl_reg > time_reg;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic               pv, pg, nv;
            logic [TICKS_W-1:0] pd, nd;
            logic [TW-1:0]      pt, nt;

            if (gi == 0)
            begin : g_head
                assign pv = 1'b1;
                assign pg = 1'b0;
                assign pd = '0;
                assign pt = '0;
            end
            else
            begin : g_body
                assign pv = cell_valid[gi-1];
                assign pg = cell_gt[gi-1];
                assign pd = cell_dl[gi-1];
                assign pt = cell_tid[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign nv = 1'b0;
                assign nd = '0;
                assign nt = '0;
            end
            else
            begin : g_mid
                assign nv = cell_valid[gi+1];
                assign nd = cell_dl[gi+1];
                assign nt = cell_tid[gi+1];
            end

            swdq_cell #(
                .TASK_W (TW)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .cmd           (cmd),
                .new_deadline  (dl_reg),
                .new_tid       (tid_reg),
                .prev_valid    (pv),
                .prev_gt       (pg),
                .prev_deadline (pd),
                .prev_tid      (pt),
                .next_valid    (nv),
                .next_deadline (nd),
                .next_tid      (nt),
                .valid         (cell_valid[gi]),
                .gt            (cell_gt[gi]),
                .deadline      (cell_dl[gi]),
                .tid           (cell_tid[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op_t'(s_tuser) == OP_TICK) ? ST_BURST : ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (op_reg == OP_TIME || !later || cell_valid[QUEUE_DEPTH-1])
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BURST:
            begin
                if (!front_due)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free && burst_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        time_next      = time_reg;
        op_next        = op_reg;
        tid_next       = tid_reg;
        dl_next        = dl_reg;
        cnt_next       = cnt_reg;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_tid_next   = out_tid_reg;
        out_ticks_next = out_ticks_reg;
        out_last_next  = out_last_reg;
        cmd            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op_t'(s_tuser);
                    tid_next = s_tdata[TW-1:0];
                    cnt_next = '0;
                    if (op_t'(s_tuser) == OP_TICK)
                    begin
                        time_next = time_reg + 32'd1;
                    end
                    if (op_t'(s_tuser) == OP_DELAY)
                    begin
                        dl_next = time_reg + TICKS_W'(req);
                    end
                    else
                    begin
                        dl_next = TICKS_W'(req);
                    end
                end
            end
            ST_DECIDE:
            begin
                out_tid_next  = TID_W'(tid_reg);
                out_last_next = 1'b1;
                priority if (op_reg == OP_TIME)
                begin
                    out_load       = out_free;
                    out_kind_next  = KIND_TIME;
                    out_ticks_next = time_reg;
                end
                else if (!later)
                begin
                    out_load       = out_free;
                    out_kind_next  = KIND_NOW;
                    out_ticks_next = dl_reg;
                end
                else if (cell_valid[QUEUE_DEPTH-1])
                begin
                    out_load       = out_free;
                    out_kind_next  = KIND_FULL;
                    out_ticks_next = dl_reg;
                end
                else
                begin
                    cmd.ins = 1'b1;
                end
            end
            ST_BURST:
            begin
                if (front_due && out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = KIND_WAKE;
                    out_tid_next   = TID_W'(cell_tid[0]);
                    out_ticks_next = time_reg;
                    out_last_next  = burst_last;
                    cmd.pop        = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        tid_reg <= tid_next;
        dl_reg  <= dl_next;
        if (out_load)
        begin
            out_kind_reg  <= out_kind_next;
            out_tid_reg   <= out_tid_next;
            out_ticks_reg <= out_ticks_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_ticks_reg, out_tid_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/swdq_cell.sv -----
// one slot of the sorted queue: holds a deadline and a task id
// depends on swdq_pkg
`default_nettype none

module swdq_cell #(
    parameter int TASK_W = swdq_pkg::TASK_ID_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire swdq_pkg::cell_cmd_t       cmd,
    input  wire logic [swdq_pkg::TICKS_W-1:0] new_deadline,
    input  wire logic [TASK_W-1:0]         new_tid,
    input  wire logic                      prev_valid,
    input  wire logic                      prev_gt,
    input  wire logic [swdq_pkg::TICKS_W-1:0] prev_deadline,
    input  wire logic [TASK_W-1:0]         prev_tid,
    input  wire logic                      next_valid,
    input  wire logic [swdq_pkg::TICKS_W-1:0] next_deadline,
    input  wire logic [TASK_W-1:0]         next_tid,
    output logic                           valid,
    output logic                           gt,
    output logic [swdq_pkg::TICKS_W-1:0]   deadline,
    output logic [TASK_W-1:0]              tid
);
    import swdq_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [TICKS_W-1:0]  deadline_reg;
    logic [TICKS_W-1:0]  deadline_next;
    logic [TASK_W-1:0]   tid_reg;
    logic [TASK_W-1:0]   tid_next;

    assign gt       = valid_reg && (deadline_reg > new_deadline);
    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign tid      = tid_reg;

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        tid_next      = tid_reg;
        priority if (cmd.pop)
        begin
            valid_next    = next_valid;
            deadline_next = next_deadline;
            tid_next      = next_tid;
        end
        else if (cmd.ins)
        begin
            priority if (prev_gt)
            begin
                valid_next    = prev_valid;
                deadline_next = prev_deadline;
                tid_next      = prev_tid;
            end
            else if (prev_valid && (gt || !valid_reg))
            begin
                valid_next    = 1'b1;
                deadline_next = new_deadline;
                tid_next      = new_tid;
            end
            else
            begin
                valid_next    = valid_reg;
                deadline_next = deadline_reg;
                tid_next      = tid_reg;
            end
        end
        else
        begin
            valid_next    = valid_reg;
            deadline_next = deadline_reg;
            tid_next      = tid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        tid_reg      <= tid_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/swdq_checker.sv -----
// port-level checks for the sorted wakeup delay queue, bound to the top level
// depends on swdq_pkg and sorted_wakeup_delay_queue
`default_nettype none

module swdq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [swdq_pkg::S_DATA_W-1:0] s_tdata,
    input wire logic [swdq_pkg::OP_W-1:0]     s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [swdq_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic [swdq_pkg::KIND_W-1:0]   m_tuser,
    input wire logic                          m_tlast
);
    import swdq_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // answers other than wakes are single words
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_WAKE) |-> m_tlast)
        else $error("non-wake answer without last");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // wake burst continues without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == KIND_WAKE) && !m_tlast
            |=> m_tvalid && (m_tuser == KIND_WAKE))
        else $error("wake burst interrupted");

    logic unused_ok;
    assign unused_ok = ^s_tdata;

endmodule

bind sorted_wakeup_delay_queue swdq_checker u_swdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
